[hw/rtl/asst_pkg.sv]
// Shared types and constants for the 1-D advection stencil step.
package asst_pkg;

    localparam int CELL_W = 16;
    localparam int IDX_W  = 7;

    localparam logic [1:0] MODE_UPWIND = 2'd0;
    localparam logic [1:0] MODE_ADVDIF = 2'd1;
    localparam logic [1:0] MODE_FLUX   = 2'd2;
    // Spare scheme code, runs as upwind
    localparam logic [1:0] MODE_ALIAS  = 2'd3;

    localparam logic [1:0] REG_SCHEME    = 2'd0;
    localparam logic [1:0] REG_COURANT   = 2'd1;
    localparam logic [1:0] REG_DIFFUSION = 2'd2;

    localparam logic [1:0]  RST_SCHEME    = MODE_UPWIND;
    localparam logic [15:0] RST_COURANT   = 16'd14746;
    localparam logic [14:0] RST_DIFFUSION = 15'd14746;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]         scheme;
        logic signed [15:0] courant;
        logic [14:0]        diffusion;
    } asst_cfg_t;

    typedef struct packed {
        logic k_eq1;
        logic k_eq2;
        logic k_ge2;
        logic last;
    } cell_flags_t;

    typedef struct packed {
        logic signed [CELL_W-1:0] cur;
        logic signed [CELL_W-1:0] prev;
        logic signed [CELL_W-1:0] older;
        logic [IDX_W-1:0]         idx;
        cell_flags_t              flags;
    } cell_entry_t;

endpackage

[hw/rtl/asst_front.sv]
// Input side: takes cells, keeps the two-cell window and the grid position.
module asst_front #(
    parameter int GRID_CELLS = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,       // [15:0] cell_value
    input  logic                queue_full,
    output logic                push,
    output asst_pkg::cell_entry_t push_data
);
    import asst_pkg::*;

    localparam int CNT_W = $clog2(GRID_CELLS);

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [CELL_W-1:0] prev_reg, older_reg;
    logic [CNT_W-1:0]        cnt_m1;
    logic                    is_last;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    assign is_last  = (cnt_reg == CNT_W'(GRID_CELLS - 1));
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_next = is_last ? '0 : cnt_reg + CNT_W'(1);

    always_comb
    begin
        push_data.cur         = $signed(s_tdata);
        push_data.prev        = prev_reg;
        push_data.older       = older_reg;
        push_data.idx         = IDX_W'(cnt_m1);
        push_data.flags.k_eq1 = (cnt_reg == CNT_W'(1));
        push_data.flags.k_eq2 = (cnt_reg == CNT_W'(2));
        push_data.flags.k_ge2 = (cnt_reg >= CNT_W'(2));
        push_data.flags.last  = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            prev_reg  <= '0;
            older_reg <= '0;
        end
        else if (push)
        begin
            cnt_reg   <= cnt_next;
            prev_reg  <= $signed(s_tdata);
            older_reg <= prev_reg;
        end
    end

endmodule

[hw/rtl/asst_queue.sv]
// Short queue of classified cells between the input side and the compute side.
module asst_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  asst_pkg::cell_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output asst_pkg::cell_entry_t pop_data,
    output logic                  empty
);
    import asst_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cell_entry_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue holds more entries than its depth");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from an empty queue");
`endif

endmodule

[hw/rtl/asst_back.sv]
// Compute side: stencil products, rounding, saturation, edge cells and result beats.
module asst_back #(
    parameter int GRID_CELLS = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  asst_pkg::asst_cfg_t   cfg,
    input  logic                  queue_empty,
    input  asst_pkg::cell_entry_t head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [6:0] cell_index, [22:7] new_value
    output logic                  m_tlast    // last_of_run
);
    import asst_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'((GRID_CELLS - 1) % 128);

    localparam logic [1:0] BEAT_INNER = 2'd0;
    localparam logic [1:0] BEAT_EDGE0 = 2'd1;
    localparam logic [1:0] BEAT_EDGE1 = 2'd2;

    function automatic logic signed [22:0] rnd14(input logic signed [36:0] v);
        logic signed [36:0] t;
        t = v + 37'sd8192;
        return t[36:14];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [23:0] v);
        logic [15:0] r;
        if (v > 24'sd32767)
            r = 16'h7fff;
        else if (v < -24'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [15:0] add_sat(input logic signed [15:0] a,
                                            input logic signed [22:0] r);
        logic signed [23:0] s;
        s = $signed({{8{a[15]}}, a}) + $signed({r[22], r});
        return sat16(s);
    endfunction

    // ---- stage 1: products ----
    logic               s1_valid_reg;
    logic signed [15:0] s1_cur_reg, s1_prev_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    cell_flags_t        s1_flags_reg;
    logic signed [32:0] s1_pa_reg, s1_pb_reg;
    logic signed [34:0] s1_pd_reg;
    logic signed [31:0] s1_pf_reg;

    logic signed [16:0] d_a, d_b;
    logic signed [18:0] d_2;
    logic signed [15:0] f_sel;
    logic signed [15:0] dn_s;
    logic signed [32:0] pa_next, pb_next;
    logic signed [34:0] pd_next;
    logic signed [31:0] pf_next;

    logic s1_adv, s1_load;

    assign d_a   = $signed({head.prev[15], head.prev}) - $signed({head.older[15], head.older});
    assign d_b   = $signed({head.cur[15], head.cur}) - $signed({head.prev[15], head.prev});
    assign d_2   = $signed({{3{head.cur[15]}}, head.cur})
                 - $signed({{2{head.prev[15]}}, head.prev, 1'b0})
                 + $signed({{3{head.older[15]}}, head.older});
    assign f_sel = cfg.courant[15] ? head.cur : head.prev;
    assign dn_s  = $signed({1'b0, cfg.diffusion});

    assign pa_next = cfg.courant * d_a;
    assign pb_next = cfg.courant * d_b;
    assign pd_next = dn_s * d_2;
    assign pf_next = cfg.courant * f_sel;

    assign s1_load = !queue_empty && (!s1_valid_reg || s1_adv);
    assign pop     = s1_load;

    // ---- stage 2: round, saturate, pick edges ----
    logic               e_valid_reg, e_three_reg;
    logic [1:0]         e_beat_reg;
    logic [IDX_W-1:0]   e_idx_reg;
    logic [15:0]        e_val0_reg, e_val1_reg, e_val2_reg;
    logic signed [17:0] prev_flux_reg;
    logic [15:0]        first_reg, second_reg;

    logic [1:0]         mode;
    logic signed [36:0] pa_x, pb_x, pd_x, pf_x;
    logic signed [22:0] flux_rnd;
    logic signed [17:0] flux;
    logic signed [18:0] flux_diff;
    logic signed [23:0] flux_sum;
    logic [15:0]        up_pos_in, up_neg_in, adv_dif_in, flux_in, up_pos_edge;
    logic [15:0]        inner, edge0, edge1;
    logic               e_done, s1_emits;

    assign mode = (cfg.scheme == MODE_ALIAS) ? MODE_UPWIND : cfg.scheme;

    assign pa_x = 37'(s1_pa_reg);
    assign pb_x = 37'(s1_pb_reg);
    assign pd_x = 37'(s1_pd_reg);
    assign pf_x = 37'(s1_pf_reg);

    assign up_pos_in   = add_sat(s1_prev_reg, rnd14(-pa_x));
    assign up_neg_in   = add_sat(s1_prev_reg, rnd14(-pb_x));
    assign adv_dif_in  = add_sat(s1_prev_reg, rnd14(pd_x - pa_x));
    assign up_pos_edge = add_sat(s1_cur_reg, rnd14(-pb_x));

    assign flux_rnd  = rnd14(pf_x);
    assign flux      = flux_rnd[17:0];
    assign flux_diff = $signed({flux[17], flux}) - $signed({prev_flux_reg[17], prev_flux_reg});
    assign flux_sum  = $signed({{8{s1_prev_reg[15]}}, s1_prev_reg})
                     - $signed({{5{flux_diff[18]}}, flux_diff});
    assign flux_in   = sat16(flux_sum);

    always_comb
    begin
        case (mode)
            MODE_ADVDIF:
            begin
                inner = adv_dif_in;
                edge0 = adv_dif_in;
                edge1 = first_reg;
            end
            MODE_FLUX:
            begin
                inner = flux_in;
                edge0 = first_reg;
                edge1 = flux_in;
            end
            default:
            begin
                if (cfg.courant > 16'sd0)
                begin
                    inner = up_pos_in;
                    edge0 = s1_cur_reg;
                    edge1 = up_pos_edge;
                end
                else
                begin
                    inner = up_neg_in;
                    edge0 = second_reg;
                    edge1 = second_reg;
                end
            end
        endcase
    end

    assign e_done   = e_valid_reg && m_tready && (!e_three_reg || e_beat_reg == BEAT_EDGE1);
    assign s1_emits = s1_flags_reg.k_ge2;
    assign s1_adv   = s1_valid_reg && (!s1_emits || !e_valid_reg || e_done);

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_cur_reg   <= head.cur;
            s1_prev_reg  <= head.prev;
            s1_idx_reg   <= head.idx;
            s1_flags_reg <= head.flags;
            s1_pa_reg    <= pa_next;
            s1_pb_reg    <= pb_next;
            s1_pd_reg    <= pd_next;
            s1_pf_reg    <= pf_next;
        end
        if (s1_adv && s1_emits)
        begin
            e_idx_reg  <= s1_idx_reg;
            e_val0_reg <= inner;
            e_val1_reg <= edge0;
            e_val2_reg <= edge1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            e_valid_reg   <= 1'b0;
            e_three_reg   <= 1'b0;
            e_beat_reg    <= BEAT_INNER;
            prev_flux_reg <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                prev_flux_reg <= flux;
                if (s1_flags_reg.k_eq1)
                begin
                    second_reg <= up_neg_in;
                end
                if (s1_flags_reg.k_eq2)
                begin
                    first_reg <= inner;
                end
            end

            // Load a fresh run of beats, else step through the current one.
            if (s1_adv && s1_emits)
            begin
                e_valid_reg <= 1'b1;
                e_three_reg <= s1_flags_reg.last;
                e_beat_reg  <= BEAT_INNER;
            end
            else if (e_done)
            begin
                e_valid_reg <= 1'b0;
                e_beat_reg  <= BEAT_INNER;
            end
            else if (e_valid_reg && m_tready)
            begin
                e_beat_reg <= e_beat_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        m_tdata = '0;
        case (e_beat_reg)
            BEAT_INNER:
            begin
                m_tdata[6:0]  = e_idx_reg;
                m_tdata[22:7] = e_val0_reg;
            end
            BEAT_EDGE0:
            begin
                m_tdata[6:0]  = '0;
                m_tdata[22:7] = e_val1_reg;
            end
            BEAT_EDGE1:
            begin
                m_tdata[6:0]  = LAST_IDX;
                m_tdata[22:7] = e_val2_reg;
            end
            default:
            begin
                m_tdata = '0;
            end
        endcase
    end

    assign m_tvalid = e_valid_reg;
    assign m_tlast  = !e_three_reg || (e_beat_reg == BEAT_EDGE1);

`ifndef SYNTH
    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> (e_beat_reg == BEAT_INNER || e_beat_reg == BEAT_EDGE0
                         || e_beat_reg == BEAT_EDGE1))
        else $error("beat counter out of range");
    a_edge_only_in_triple: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && e_beat_reg != BEAT_INNER) |-> e_three_reg)
        else $error("edge beat outside an end-of-grid run");
    a_edge0_then_edge1: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && m_tready && e_beat_reg == BEAT_EDGE0)
        |=> (e_valid_reg && e_beat_reg == BEAT_EDGE1))
        else $error("second edge beat did not follow the first");
`endif

endmodule

[hw/rtl/advection_stencil_step_1d_top.sv]
// A result beat passes through the queue, the product registers and the result registers before it is offered.
// Throughput: one cell per cycle while the queue is not full; cells from the third on yield one beat, the last three.
// The result for cell i follows cell i+1; cells 0 and G-1 follow the last cell of the grid.
// The final cell of a grid holds the result stage until both edge cells have been sent.
// Reset: clears the queue, the grid position and the stencil window; registers take defaults.
// Configuration writes are taken every cycle; write only while no cell is in flight.
module advection_stencil_step_1d_top #(
    parameter int GRID_CELLS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] cell_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [6:0] cell_index, [22:7] new_value, [23] zero
    output logic        m_tlast,      // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import asst_pkg::*;

    asst_cfg_t   cfg_reg;
    cell_entry_t push_data, head;
    logic        push, pop, queue_full, queue_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scheme    <= RST_SCHEME;
            cfg_reg.courant   <= RST_COURANT;
            cfg_reg.diffusion <= RST_DIFFUSION;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCHEME:    cfg_reg.scheme    <= cfg_data[1:0];
                REG_COURANT:   cfg_reg.courant   <= $signed(cfg_data);
                REG_DIFFUSION: cfg_reg.diffusion <= cfg_data[14:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    asst_front #(
        .GRID_CELLS (GRID_CELLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    asst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (queue_empty)
    );

    asst_back #(
        .GRID_CELLS (GRID_CELLS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
